// File: hdl/ppk_pkg.sv
`default_nettype none
package ppk_pkg;

   localparam int TableEntriesDefault = 1024;

   typedef enum logic [2:0] {
      CMD_REGISTER = 3'd0,
      CMD_ORDER    = 3'd1,
      CMD_CANCEL   = 3'd2,
      CMD_FILL     = 3'd3,
      CMD_QUERY    = 3'd4
   } cmd_code_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_ABSENT = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef struct packed {
      cmd_code_type op;
      logic         insert;
      logic [63:0]  key;
      logic         sell;
      logic [30:0]  qty;
      logic [31:0]  price;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] filled;
      logic [63:0] pending;
      logic [63:0] exposure;
      logic [63:0] cost;
      logic [63:0] profit;
   } rsp_type;

endpackage
`default_nettype wire

// File: hdl/ppk_ram.sv
`default_nettype none
module ppk_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// File: hdl/ppk_fifo.sv
`default_nettype none
module ppk_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             rd,
   output logic      [WIDTH-1:0] rdata,
   output logic                  full,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic do_wr, do_rd;

   assign full  = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign do_wr = wr && !full;
   assign do_rd = rd && !empty;
   assign rdata = data_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_wr) begin
         wp_in = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (do_rd) begin
         rp_in = (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_wr) begin
         data_ff[wp_ff] <= wdata;
      end
   end
endmodule
`default_nettype wire

// File: hdl/ppk_front.sv
`default_nettype none
module ppk_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   output logic                 full,
   input  wire logic [2:0]      req_command,
   input  wire logic [63:0]     req_symbol_key,
   input  wire logic            req_side,
   input  wire logic [30:0]     req_quantity,
   input  wire logic [31:0]     req_price_scaled,
   input  wire logic            cmd_pop,
   output ppk_pkg::cmd_type     cmd_head,
   output logic                 cmd_empty
);
   ppk_pkg::cmd_type cls;
   logic [$bits(ppk_pkg::cmd_type)-1:0] head_bits;

   // unused codes behave as a query
   always_comb begin
      cls.key   = req_symbol_key;
      cls.sell  = req_side;
      cls.qty   = req_quantity;
      cls.price = req_price_scaled;
      unique case (req_command)
         ppk_pkg::CMD_REGISTER: cls.op = ppk_pkg::CMD_REGISTER;
         ppk_pkg::CMD_ORDER:    cls.op = ppk_pkg::CMD_ORDER;
         ppk_pkg::CMD_CANCEL:   cls.op = ppk_pkg::CMD_CANCEL;
         ppk_pkg::CMD_FILL:     cls.op = ppk_pkg::CMD_FILL;
         default:               cls.op = ppk_pkg::CMD_QUERY;
      endcase
      cls.insert = (cls.op == ppk_pkg::CMD_REGISTER) || (cls.op == ppk_pkg::CMD_ORDER) ||
                   (cls.op == ppk_pkg::CMD_FILL);
   end

   ppk_fifo #(.WIDTH($bits(ppk_pkg::cmd_type)), .DEPTH(2)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .wr    (push),
      .wdata (cls),
      .rd    (cmd_pop),
      .rdata (head_bits),
      .full  (full),
      .empty (cmd_empty)
   );

   assign cmd_head = ppk_pkg::cmd_type'(head_bits);
endmodule
`default_nettype wire

// File: hdl/ppk_engine.sv
`default_nettype none
module ppk_engine #(
   parameter int TABLE_ENTRIES = ppk_pkg::TableEntriesDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ppk_pkg::cmd_type cmd_head,
   input  wire logic             cmd_empty,
   output logic                  cmd_pop,
   output ppk_pkg::rsp_type      rsp_data,
   output logic                  rsp_push,
   input  wire logic             rsp_full
);
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD, S_CHK, S_OPER, S_F1, S_F2, S_F3, S_DIV, S_FIN, S_DONE
   } state_type;

   state_type state_ff;
   ppk_pkg::cmd_type cmd_ff;
   logic [AW-1:0] idx_ff, clr_ff;
   logic [AW:0] cnt_ff;
   ppk_pkg::status_type status_ff;
   logic [63:0] filled_ff, pending_ff, cost_ff, profit_ff;
   logic cov_ff;
   logic [30:0] c_ff, rest_ff;
   logic [62:0] pc_ff, pr_ff, plo_ff;
   logic [63:0] amag_ff, d_ff, q_ff, rem_ff;
   logic [95:0] prod_ff;
   logic [6:0] step_ff;

   logic key_we;
   logic [AW-1:0] key_waddr;
   logic [64:0] key_wdata, key_rd;
   logic [255:0] val_rd;
   logic val_we;

   logic [AW:0] start_ext;
   logic [AW-1:0] start_idx, idx_next;
   logic [63:0] fmag, cand_c, sq;
   logic buy_cov, sell_cov;
   logic [64:0] r_try;
   logic [63:0] rem_amt;

   assign start_ext = {1'b0, cmd_head.key[AW-1:0]};
   assign start_idx = (start_ext >= (AW+1)'(TABLE_ENTRIES)) ?
                      AW'(start_ext - (AW+1)'(TABLE_ENTRIES)) : AW'(start_ext);
   assign idx_next  = (idx_ff == AW'(TABLE_ENTRIES - 1)) ? '0 : idx_ff + 1'b1;

   assign key_we    = (state_ff == S_CLEAR) ||
                      (state_ff == S_CHK && !key_rd[64] && cmd_ff.insert);
   assign key_waddr = (state_ff == S_CLEAR) ? clr_ff : idx_ff;
   assign key_wdata = (state_ff == S_CLEAR) ? 65'd0 : {1'b1, cmd_ff.key};
   assign val_we    = (state_ff == S_DONE) && (status_ff == ppk_pkg::ST_OK);

   ppk_ram #(.WIDTH(65), .DEPTH(TABLE_ENTRIES)) u_key_ram (
      .clock (clock), .we (key_we), .waddr (key_waddr), .wdata (key_wdata),
      .raddr (idx_ff), .rdata (key_rd)
   );

   ppk_ram #(.WIDTH(256), .DEPTH(TABLE_ENTRIES)) u_val_ram (
      .clock (clock), .we (val_we), .waddr (idx_ff),
      .wdata ({filled_ff, pending_ff, cost_ff, profit_ff}),
      .raddr (idx_ff), .rdata (val_rd)
   );

   // fill classification on the entry's filled quantity
   assign fmag     = filled_ff[63] ? 64'd0 - filled_ff : filled_ff;
   assign buy_cov  = !cmd_ff.sell && filled_ff[63];
   assign sell_cov = cmd_ff.sell && (filled_ff != '0) && !filled_ff[63];
   assign cand_c   = ({33'd0, cmd_ff.qty} < fmag) ? {33'd0, cmd_ff.qty} : fmag;
   assign sq       = cmd_ff.sell ? 64'd0 - {33'd0, cmd_ff.qty} : {33'd0, cmd_ff.qty};

   assign r_try   = {rem_ff, prod_ff[95]};
   assign rem_amt = (cost_ff[63] ^ filled_ff[63]) ? 64'd0 - q_ff : q_ff;

   assign cmd_pop  = (state_ff == S_IDLE) && !cmd_empty;
   assign rsp_push = (state_ff == S_DONE) && !rsp_full;

   always_comb begin
      rsp_data.status = status_ff;
      if (status_ff == ppk_pkg::ST_OK) begin
         rsp_data.filled   = filled_ff;
         rsp_data.pending  = pending_ff;
         rsp_data.exposure = filled_ff + pending_ff;
         rsp_data.cost     = cost_ff;
         rsp_data.profit   = profit_ff;
      end else begin
         rsp_data.filled   = '0;
         rsp_data.pending  = '0;
         rsp_data.exposure = '0;
         rsp_data.cost     = '0;
         rsp_data.profit   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(TABLE_ENTRIES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (!cmd_empty) begin
                  cmd_ff   <= cmd_head;
                  idx_ff   <= start_idx;
                  cnt_ff   <= '0;
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (!key_rd[64]) begin
                  if (cmd_ff.insert) begin
                     status_ff  <= ppk_pkg::ST_OK;
                     filled_ff  <= '0;
                     pending_ff <= '0;
                     cost_ff    <= '0;
                     profit_ff  <= '0;
                     state_ff   <= S_OPER;
                  end else begin
                     status_ff <= ppk_pkg::ST_ABSENT;
                     state_ff  <= S_DONE;
                  end
               end else if (key_rd[63:0] == cmd_ff.key) begin
                  status_ff  <= ppk_pkg::ST_OK;
                  filled_ff  <= val_rd[255:192];
                  pending_ff <= val_rd[191:128];
                  cost_ff    <= val_rd[127:64];
                  profit_ff  <= val_rd[63:0];
                  state_ff   <= S_OPER;
               end else if (cnt_ff == (AW+1)'(TABLE_ENTRIES - 1)) begin
                  status_ff <= cmd_ff.insert ? ppk_pkg::ST_FULL : ppk_pkg::ST_ABSENT;
                  state_ff  <= S_DONE;
               end else begin
                  idx_ff   <= idx_next;
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_OPER: begin
               unique case (cmd_ff.op)
                  ppk_pkg::CMD_ORDER: begin
                     pending_ff <= pending_ff + sq;
                     state_ff   <= S_DONE;
                  end
                  ppk_pkg::CMD_CANCEL: begin
                     pending_ff <= pending_ff - sq;
                     state_ff   <= S_DONE;
                  end
                  ppk_pkg::CMD_FILL: begin
                     cov_ff   <= (buy_cov || sell_cov) && (cand_c != '0);
                     c_ff     <= (buy_cov || sell_cov) ? cand_c[30:0] : '0;
                     rest_ff  <= cmd_ff.qty - ((buy_cov || sell_cov) ? cand_c[30:0] : 31'd0);
                     amag_ff  <= cost_ff[63] ? 64'd0 - cost_ff : cost_ff;
                     d_ff     <= fmag;
                     state_ff <= S_F1;
                  end
                  default: begin
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_F1: begin
               pc_ff    <= 63'(cmd_ff.price * c_ff);
               plo_ff   <= 63'(amag_ff[31:0] * c_ff);
               state_ff <= S_F2;
            end
            S_F2: begin
               pr_ff    <= 63'(cmd_ff.price * rest_ff);
               prod_ff  <= {33'd0, 63'(amag_ff[63:32] * c_ff)} << 32;
               state_ff <= S_F3;
            end
            S_F3: begin
               prod_ff  <= prod_ff + {33'd0, plo_ff};
               rem_ff   <= '0;
               q_ff     <= '0;
               step_ff  <= '0;
               state_ff <= cov_ff ? S_DIV : S_FIN;
            end
            S_DIV: begin
               // restoring divide, one quotient bit per cycle
               prod_ff <= prod_ff << 1;
               if (r_try >= {1'b0, d_ff}) begin
                  rem_ff <= 64'(r_try - {1'b0, d_ff});
                  q_ff   <= {q_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= r_try[63:0];
                  q_ff   <= {q_ff[62:0], 1'b0};
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == 7'd95) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (!cmd_ff.sell) begin
                  if (cov_ff) begin
                     profit_ff <= profit_ff + rem_amt - {1'b0, pc_ff};
                     cost_ff   <= cost_ff + rem_amt + {1'b0, pr_ff};
                  end else begin
                     cost_ff   <= cost_ff + {1'b0, pr_ff};
                  end
                  filled_ff  <= filled_ff + {33'd0, cmd_ff.qty};
                  pending_ff <= pending_ff - {33'd0, cmd_ff.qty};
               end else begin
                  if (cov_ff) begin
                     profit_ff <= profit_ff + {1'b0, pc_ff} - rem_amt;
                     cost_ff   <= cost_ff - rem_amt - {1'b0, pr_ff};
                  end else begin
                     cost_ff   <= cost_ff - {1'b0, pr_ff};
                  end
                  filled_ff  <= filled_ff - {33'd0, cmd_ff.qty};
                  pending_ff <= pending_ff + {33'd0, cmd_ff.qty};
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_full) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

// File: hdl/position_pnl_keeper_core.sv
`default_nettype none
// channel   ports                     direction  handshake
// request   req_* (5 fields)          in         push / full
// response  rsp_* (6 fields)          out        empty / pop
//
// the engine takes a transaction from the request queue, reads and checks each
// probed slot (S_RD, S_CHK), then on a hit or insert passes S_OPER and S_DONE for
// a register, order, cancel or query; a plain fill passes S_F1, S_F2, S_F3 and
// S_FIN, a covering fill also the serial divide (S_DIV, one quotient bit per cycle);
// a full response queue holds the engine in S_DONE; after reset every key slot is
// cleared before the first transaction is taken from the request queue
// request and response queues hold two transactions each
module position_pnl_keeper_core #(
   parameter int TABLE_ENTRIES = ppk_pkg::TableEntriesDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic [2:0]         req_command,
   input  wire logic [63:0]        req_symbol_key,
   input  wire logic               req_side,
   input  wire logic [30:0]        req_quantity,
   input  wire logic [31:0]        req_price_scaled,
   output logic                    empty,
   input  wire logic               pop,
   output logic [1:0]              rsp_status,
   output logic signed [63:0]      rsp_filled_position,
   output logic signed [63:0]      rsp_pending_position,
   output logic signed [63:0]      rsp_total_exposure,
   output logic signed [63:0]      rsp_cost_basis_out,
   output logic signed [63:0]      rsp_realized_profit
);
   ppk_pkg::cmd_type cmd_head;
   logic cmd_empty, cmd_pop;
   ppk_pkg::rsp_type rsp_in, rsp_out;
   logic rsp_push, rsp_full;
   logic [$bits(ppk_pkg::rsp_type)-1:0] rsp_bits;

   ppk_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_command      (req_command),
      .req_symbol_key   (req_symbol_key),
      .req_side         (req_side),
      .req_quantity     (req_quantity),
      .req_price_scaled (req_price_scaled),
      .cmd_pop          (cmd_pop),
      .cmd_head         (cmd_head),
      .cmd_empty        (cmd_empty)
   );

   ppk_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_data  (rsp_in),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   ppk_fifo #(.WIDTH($bits(ppk_pkg::rsp_type)), .DEPTH(2)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .wr    (rsp_push),
      .wdata (rsp_in),
      .rd    (pop),
      .rdata (rsp_bits),
      .full  (rsp_full),
      .empty (empty)
   );

   assign rsp_out              = ppk_pkg::rsp_type'(rsp_bits);
   assign rsp_status           = rsp_out.status;
   assign rsp_filled_position  = rsp_out.filled;
   assign rsp_pending_position = rsp_out.pending;
   assign rsp_total_exposure   = rsp_out.exposure;
   assign rsp_cost_basis_out   = rsp_out.cost;
   assign rsp_realized_profit  = rsp_out.profit;
endmodule
`default_nettype wire
